// File: rtl/gccu_pkg.sv
// ----------------------------------------------------------------------------
// gccu_pkg
// Shared types and constants for the generalized CRT combiner
// ----------------------------------------------------------------------------
package gccu_pkg;

    localparam int VALUE_BITS_DEF = 63;
    localparam int FIELD_BITS     = 63;

    typedef struct packed {
        logic [FIELD_BITS-1:0] modulus;
        logic [FIELD_BITS-1:0] residue;
        logic                  start_new;
    } t_in_req;

    typedef struct packed {
        logic [FIELD_BITS-1:0] solution;
        logic [FIELD_BITS-1:0] combined_modulus;
        logic [1:0]            status;
    } t_out_req;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_NOSOL = 2'd1,
        ST_OVF   = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        OP_DIV    = 2'd0,
        OP_MULMOD = 2'd1,
        OP_MUL    = 2'd2
    } t_alu_op;

endpackage

// File: rtl/gccu_alu.sv
// ----------------------------------------------------------------------------
// gccu_alu
// Shared bit-serial unit: restoring divide, modular multiply, plain multiply
// ----------------------------------------------------------------------------
module gccu_alu #(
    parameter int W = gccu_pkg::VALUE_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  gccu_pkg::t_alu_op i_op,
    input  logic [W-1:0]      i_a,
    input  logic [W-1:0]      i_b,
    input  logic [W-1:0]      i_m,
    output logic              o_done,
    output logic [W-1:0]      o_quo,
    output logic [W-1:0]      o_res
);
    import gccu_pkg::*;

    localparam int CW = $clog2(W + 1);

    logic          r_busy;
    logic          r_done;
    logic          r_phase;
    t_alu_op       r_op;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_sh;
    logic [W-1:0]  r_add;
    logic [W-1:0]  r_mod;
    logic [W:0]    r_acc;

    logic [W:0]    cand;
    logic [W+1:0]  diff;
    logic          ge;
    logic [W:0]    red;
    logic          last;

    always_comb begin
        case (r_op)
            OP_DIV:    cand = {r_acc[W-1:0], r_sh[W-1]};
            OP_MULMOD: cand = r_phase ? (r_sh[W-1] ? r_acc + {1'b0, r_add} : r_acc)
                                      : {r_acc[W-1:0], 1'b0};
            OP_MUL:    cand = {r_acc[W-1:0], 1'b0} + (r_sh[W-1] ? {1'b0, r_add} : '0);
            default:   cand = r_acc;
        endcase
        diff = {1'b0, cand} - {2'b00, r_mod};
        ge   = !diff[W+1];
        red  = ge ? diff[W:0] : cand;
        last = (r_cnt == CW'(W - 1));
    end

    always_ff @(posedge i_clk) begin
        r_done <= 1'b0;
        if (i_start) begin
            r_busy  <= 1'b1;
            r_op    <= i_op;
            r_phase <= 1'b0;
            r_cnt   <= '0;
            r_acc   <= '0;
            if (i_op == OP_DIV) begin
                r_sh  <= i_a;
                r_mod <= i_b;
                r_add <= '0;
            end else begin
                r_sh  <= i_b;
                r_add <= i_a;
                r_mod <= i_m;
            end
        end else if (r_busy) begin
            case (r_op)
                OP_DIV: begin
                    r_acc <= red;
                    r_sh  <= {r_sh[W-2:0], ge};
                    r_cnt <= r_cnt + 1'b1;
                    if (last) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                end
                OP_MULMOD: begin
                    // phase 0 doubles, phase 1 adds the operand when the multiplier bit is set, both reduced
                    r_acc   <= red;
                    r_phase <= !r_phase;
                    if (r_phase) begin
                        r_sh  <= {r_sh[W-2:0], 1'b0};
                        r_cnt <= r_cnt + 1'b1;
                        if (last) begin
                            r_busy <= 1'b0;
                            r_done <= 1'b1;
                        end
                    end
                end
                default: begin
                    r_acc <= cand;
                    r_sh  <= {r_sh[W-2:0], 1'b0};
                    r_cnt <= r_cnt + 1'b1;
                    if (last) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                end
            endcase
        end
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_sh;
    assign o_res  = r_acc[W-1:0];

endmodule

// File: rtl/generalized_crt_combiner_unit.sv
// ----------------------------------------------------------------------------
// generalized_crt_combiner_unit
// Merges a stream of congruences into one running congruence
// ----------------------------------------------------------------------------
// Each request carries one congruence x = residue (mod modulus); start_new opens
// a new system. The block merges it into the running residue and modulus and
// returns one result per request: the smallest solution, the lcm of the moduli
// and a sticky status (ok, no solution, overflow). All arithmetic runs on one
// bit-serial unit. The block takes no new request until the current one has
// finished; a finished result waits in the output register.
module generalized_crt_combiner_unit #(
    parameter int VALUE_BITS = gccu_pkg::VALUE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  gccu_pkg::t_in_req  i_in_req,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output gccu_pkg::t_out_req o_out_req
);
    import gccu_pkg::*;

    localparam int W = VALUE_BITS;
    localparam logic [W-1:0] MASK = {W{1'b1}};

    typedef enum logic [4:0] {
        S_IDLE, S_R2, S_GCD_CHK, S_GCD_DIV, S_R1G, S_R2G, S_N, S_LIM,
        S_D1, S_D2, S_X1, S_X2, S_INV_CHK, S_INV_DIV, S_INV_QM, S_INV_QS,
        S_K, S_MULK, S_MULN, S_OUT
    } t_state;

    t_state       r_state;
    t_status      r_status;
    logic [W-1:0] r_acc_mod;
    logic [W-1:0] r_acc_res;
    logic [W-1:0] r_m2, r_r2;
    logic         r_fresh;
    logic [W-1:0] r_ga, r_gb, r_g, r_n, r_t, r_d;
    logic         r_neg;
    logic [W-1:0] r_e0, r_e1, r_s0, r_s1;
    logic         r_out_valid;
    t_out_req     r_out_req;

    logic         r_alu_start;
    t_alu_op      r_alu_op;
    logic [W-1:0] r_alu_a, r_alu_b, r_alu_m;
    logic         alu_done;
    logic [W-1:0] alu_quo, alu_res;

    logic [W-1:0] n_m2;
    logic [W-1:0] n_s1;

    gccu_alu #(.W(W)) u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_alu_start),
        .i_op    (r_alu_op),
        .i_a     (r_alu_a),
        .i_b     (r_alu_b),
        .i_m     (r_alu_m),
        .o_done  (alu_done),
        .o_quo   (alu_quo),
        .o_res   (alu_res)
    );

    always_comb begin
        n_m2 = (i_in_req.modulus[W-1:0] == '0) ? W'(1) : i_in_req.modulus[W-1:0];
        // new coefficient kept modulo n
        n_s1 = (r_s0 >= alu_res) ? (r_s0 - alu_res) : (r_s0 + (r_n - alu_res));
    end

    always_ff @(posedge i_clk) begin
        r_alu_start <= 1'b0;
        if (r_out_valid && i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    r_m2        <= n_m2;
                    r_fresh     <= i_in_req.start_new;
                    r_alu_start <= 1'b1;
                    r_alu_op    <= OP_DIV;
                    r_alu_a     <= i_in_req.residue[W-1:0];
                    r_alu_b     <= n_m2;
                    r_state     <= S_R2;
                end
            end
            S_R2: begin
                if (alu_done) begin
                    r_r2 <= alu_res;
                    if (r_fresh) begin
                        r_acc_mod <= r_m2;
                        r_acc_res <= alu_res;
                        r_status  <= ST_OK;
                        r_state   <= S_OUT;
                    end else if (r_status != ST_OK) begin
                        r_state <= S_OUT;
                    end else begin
                        r_ga    <= r_acc_mod;
                        r_gb    <= r_m2;
                        r_state <= S_GCD_CHK;
                    end
                end
            end
            S_GCD_CHK: begin
                r_alu_start <= 1'b1;
                r_alu_op    <= OP_DIV;
                if (r_gb == '0) begin
                    r_g     <= r_ga;
                    r_alu_a <= r_acc_res;
                    r_alu_b <= r_ga;
                    r_state <= S_R1G;
                end else begin
                    r_alu_a <= r_ga;
                    r_alu_b <= r_gb;
                    r_state <= S_GCD_DIV;
                end
            end
            S_GCD_DIV: begin
                if (alu_done) begin
                    r_ga    <= r_gb;
                    r_gb    <= alu_res;
                    r_state <= S_GCD_CHK;
                end
            end
            S_R1G: begin
                if (alu_done) begin
                    r_t         <= alu_res;
                    r_alu_start <= 1'b1;
                    r_alu_a     <= r_r2;
                    r_alu_b     <= r_g;
                    r_state     <= S_R2G;
                end
            end
            S_R2G: begin
                if (alu_done) begin
                    if (alu_res != r_t) begin
                        r_status <= ST_NOSOL;
                        r_state  <= S_OUT;
                    end else begin
                        r_alu_start <= 1'b1;
                        r_alu_a     <= r_m2;
                        r_alu_b     <= r_g;
                        r_state     <= S_N;
                    end
                end
            end
            S_N: begin
                if (alu_done) begin
                    r_n         <= alu_quo;
                    r_alu_start <= 1'b1;
                    r_alu_a     <= MASK;
                    r_alu_b     <= r_acc_mod;
                    r_state     <= S_LIM;
                end
            end
            S_LIM: begin
                if (alu_done) begin
                    if (r_n > alu_quo) begin
                        r_status <= ST_OVF;
                        r_state  <= S_OUT;
                    end else if (r_n == W'(1)) begin
                        // trivial merge leaves the state as it is
                        r_state <= S_OUT;
                    end else begin
                        r_alu_start <= 1'b1;
                        r_alu_b     <= r_g;
                        r_neg       <= (r_r2 < r_acc_res);
                        r_alu_a     <= (r_r2 >= r_acc_res) ? (r_r2 - r_acc_res)
                                                           : (r_acc_res - r_r2);
                        r_state     <= S_D1;
                    end
                end
            end
            S_D1: begin
                if (alu_done) begin
                    r_alu_start <= 1'b1;
                    r_alu_a     <= alu_quo;
                    r_alu_b     <= r_n;
                    r_state     <= S_D2;
                end
            end
            S_D2: begin
                if (alu_done) begin
                    r_d <= (r_neg && alu_res != '0) ? (r_n - alu_res) : alu_res;
                    r_alu_start <= 1'b1;
                    r_alu_a     <= r_acc_mod;
                    r_alu_b     <= r_g;
                    r_state     <= S_X1;
                end
            end
            S_X1: begin
                if (alu_done) begin
                    r_alu_start <= 1'b1;
                    r_alu_a     <= alu_quo;
                    r_alu_b     <= r_n;
                    r_state     <= S_X2;
                end
            end
            S_X2: begin
                if (alu_done) begin
                    r_e0    <= alu_res;
                    r_e1    <= r_n;
                    r_s0    <= W'(1);
                    r_s1    <= '0;
                    r_state <= S_INV_CHK;
                end
            end
            S_INV_CHK: begin
                r_alu_start <= 1'b1;
                if (r_e1 == '0) begin
                    r_alu_op <= OP_MULMOD;
                    r_alu_a  <= r_d;
                    r_alu_b  <= r_s0;
                    r_alu_m  <= r_n;
                    r_state  <= S_K;
                end else begin
                    r_alu_op <= OP_DIV;
                    r_alu_a  <= r_e0;
                    r_alu_b  <= r_e1;
                    r_state  <= S_INV_DIV;
                end
            end
            S_INV_DIV: begin
                if (alu_done) begin
                    r_e0        <= r_e1;
                    r_e1        <= alu_res;
                    r_alu_start <= 1'b1;
                    r_alu_a     <= alu_quo;
                    r_alu_b     <= r_n;
                    r_state     <= S_INV_QM;
                end
            end
            S_INV_QM: begin
                if (alu_done) begin
                    r_alu_start <= 1'b1;
                    r_alu_op    <= OP_MULMOD;
                    r_alu_a     <= alu_res;
                    r_alu_b     <= r_s1;
                    r_alu_m     <= r_n;
                    r_state     <= S_INV_QS;
                end
            end
            S_INV_QS: begin
                if (alu_done) begin
                    r_s0     <= r_s1;
                    r_s1     <= n_s1;
                    r_alu_op <= OP_DIV;
                    r_state  <= S_INV_CHK;
                end
            end
            S_K: begin
                if (alu_done) begin
                    r_alu_start <= 1'b1;
                    r_alu_op    <= OP_MUL;
                    r_alu_a     <= alu_res;
                    r_alu_b     <= r_acc_mod;
                    r_state     <= S_MULK;
                end
            end
            S_MULK: begin
                if (alu_done) begin
                    r_t         <= r_acc_res + alu_res;
                    r_alu_start <= 1'b1;
                    r_alu_a     <= r_acc_mod;
                    r_alu_b     <= r_n;
                    r_state     <= S_MULN;
                end
            end
            S_MULN: begin
                if (alu_done) begin
                    r_acc_mod <= alu_res;
                    r_acc_res <= r_t;
                    r_alu_op  <= OP_DIV;
                    r_state   <= S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    r_out_valid                <= 1'b1;
                    r_out_req.solution         <= FIELD_BITS'(r_acc_res);
                    r_out_req.combined_modulus <= FIELD_BITS'(r_acc_mod);
                    r_out_req.status           <= r_status;
                    r_state                    <= S_IDLE;
                end
            end
            default: begin
                r_state <= S_IDLE;
            end
        endcase
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_status    <= ST_OK;
            r_acc_mod   <= W'(1);
            r_acc_res   <= '0;
            r_out_valid <= 1'b0;
            r_alu_start <= 1'b0;
            r_alu_op    <= OP_DIV;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out_req;

endmodule

// File: rtl/gccu_checker.sv
// ----------------------------------------------------------------------------
// gccu_checker
// Port-level checks for the CRT combiner, bound to the top level
// ----------------------------------------------------------------------------
module gccu_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input gccu_pkg::t_in_req  i_in_req,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input gccu_pkg::t_out_req o_out_req
);
    import gccu_pkg::*;

    // a stalled result stays
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_req))
        else $error("result changed while stalled");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_req.status != 2'd3))
        else $error("bad status code");

    a_mod_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_req.combined_modulus != '0))
        else $error("zero combined modulus");

    // one request at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready right after a request");

endmodule

bind generalized_crt_combiner_unit gccu_checker u_gccu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_req    (i_in_req),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_req   (o_out_req)
);

// File: bench/generalized_crt_combiner_unit_tb.sv
// ----------------------------------------------------------------------------
// generalized_crt_combiner_unit_tb
// Self-checking bench for the generalized CRT combiner
// ----------------------------------------------------------------------------
// Requests go in through the valid/ready input channel; a local model of the
// congruence merge predicts every result, and a monitor compares each accepted
// result field by field. Phases vary sender gaps and receiver stalls, and one
// phase holds the output back for a long stretch so the block backs up.
// ----------------------------------------------------------------------------
module generalized_crt_combiner_unit_tb;
    import gccu_pkg::*;

    localparam int VBITS = 63;
    localparam logic [63:0] VMASK = (64'd1 << VBITS) - 64'd1;
    localparam int CYCLE_LIMIT = 200000000;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     in_valid = 1'b0;
    logic     in_ready;
    t_in_req  in_req = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    t_out_req out_req;

    t_out_req expected_results[$];
    int       errors = 0;
    int       cycles = 0;
    int       send_idle_pct = 0;
    int       recv_stall_pct = 0;
    int       hold_off = 0;
    int       items_sent = 0;

    // running congruence of the local model
    logic [63:0] crt_mod = 64'd1;
    logic [63:0] crt_res = 64'd0;
    t_status     crt_status = ST_OK;

    generalized_crt_combiner_unit #(.VALUE_BITS(VBITS)) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_req   (in_req),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_req  (out_req)
    );

    always #1 clk = ~clk;

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic [63:0] mulmod(logic [63:0] a, logic [63:0] b,
                                           logic [63:0] m);
        logic [127:0] p;
        p = a * b;
        return 64'(p % m);
    endfunction

    function automatic logic [63:0] gcd64(logic [63:0] a, logic [63:0] b);
        logic [63:0] t;
        while (b != 64'd0) begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    function automatic logic [63:0] inverse(logic [63:0] a, logic [63:0] m);
        logic [63:0] r0, r1, s0, s1, q, t, qs, ns;
        r0 = a; r1 = m; s0 = 64'd1; s1 = 64'd0;
        while (r1 != 64'd0) begin
            q = r0 / r1;
            t = r0 - q * r1;
            qs = mulmod(q % m, s1, m);
            ns = (s0 >= qs) ? s0 - qs : s0 + (m - qs);
            r0 = r1; r1 = t; s0 = s1; s1 = ns;
        end
        return s0 % m;
    endfunction

    function automatic t_out_req merge_congruence(t_in_req r);
        logic [63:0] m2, r2, g, n, d, k;
        t_out_req o;
        m2 = {1'b0, r.modulus} & VMASK;
        if (m2 == 64'd0) m2 = 64'd1;
        r2 = ({1'b0, r.residue} & VMASK) % m2;
        if (r.start_new) begin
            crt_mod = m2; crt_res = r2; crt_status = ST_OK;
        end else if (crt_status == ST_OK) begin
            g = gcd64(crt_mod, m2);
            if ((crt_res % g) != (r2 % g)) begin
                crt_status = ST_NOSOL;
            end else begin
                n = m2 / g;
                if (n > VMASK / crt_mod) begin
                    crt_status = ST_OVF;
                end else begin
                    k = 64'd0;
                    if (n > 64'd1) begin
                        if (r2 >= crt_res) begin
                            d = ((r2 - crt_res) / g) % n;
                        end else begin
                            d = ((crt_res - r2) / g) % n;
                            d = (n - d) % n;
                        end
                        k = mulmod(d, inverse((crt_mod / g) % n, n), n);
                    end
                    crt_res = crt_res + k * crt_mod;
                    crt_mod = crt_mod * n;
                end
            end
        end
        o.solution = crt_res[62:0];
        o.combined_modulus = crt_mod[62:0];
        o.status = crt_status;
        return o;
    endfunction

    // result checker
    always @(posedge clk) begin
        t_out_req e;
        if (rst_n && out_valid && out_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, out_req);
                errors++;
            end else begin
                e = expected_results.pop_front();
                if (e.solution !== out_req.solution) begin
                    $display("%0t: solution exp %h got %h", $time, e.solution,
                             out_req.solution);
                    errors++;
                end
                if (e.combined_modulus !== out_req.combined_modulus) begin
                    $display("%0t: modulus exp %h got %h", $time,
                             e.combined_modulus, out_req.combined_modulus);
                    errors++;
                end
                if (e.status !== out_req.status) begin
                    $display("%0t: status exp %0d got %0d", $time, e.status,
                             out_req.status);
                    errors++;
                end
            end
        end
    end

    // receiver: random stalls, plus a long hold-off when requested
    always @(negedge clk) begin
        if (hold_off > 0) begin
            out_ready <= 1'b0;
            hold_off <= hold_off - 1;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // valid stays up into the next request unless the sender idles
    task automatic send_congruence(logic [62:0] m, logic [62:0] r, logic s);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_req <= '{modulus: m, residue: r, start_new: s};
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        expected_results.push_back(merge_congruence('{modulus: m, residue: r,
                                                      start_new: s}));
        items_sent++;
        @(negedge clk);
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (expected_results.size() != 0) @(negedge clk);
        repeat (50) @(negedge clk);
    endtask

    function automatic logic [62:0] rand63();
        return 63'({$urandom(), $urandom()});
    endfunction

    // small moduli so systems keep merging for a while
    task automatic send_random_system();
        int len;
        logic [62:0] m;
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) begin
            case ($urandom_range(9))
                0: m = rand63();
                1: m = 63'($urandom_range(1, 1 << 20));
                default: m = 63'($urandom_range(1, 300));
            endcase
            if ($urandom_range(9) == 0) m = '0;
            send_congruence(m, ($urandom_range(9) == 0) ? rand63()
                            : 63'($urandom()) % ((m == '0) ? 63'd1 : m), i == 0);
        end
    endtask

    task automatic test_directed();
        send_congruence(63'd3, 63'd2, 1'b0);          // first item without start
        send_congruence(63'd5, 63'd3, 1'b0);
        send_congruence(63'd7, 63'd2, 1'b0);
        send_congruence(63'd0, 63'd9, 1'b0);          // zero modulus
        send_congruence(63'd6, 63'd5, 1'b1);
        send_congruence(63'd4, 63'd2, 1'b0);          // no solution
        send_congruence(63'd5, 63'd1, 1'b0);          // sticky
        send_congruence(63'd4, 63'd11, 1'b1);         // residue above modulus
        send_congruence(63'd6, 63'd1, 1'b0);
        send_congruence({63{1'b1}}, {63{1'b1}}, 1'b1);
        send_congruence(63'd2, 63'd0, 1'b0);          // overflow
        send_congruence(63'd3, 63'd0, 1'b0);
        send_congruence(63'd1, 63'd0, 1'b1);
        send_congruence({63{1'b1}}, 63'd12345, 1'b0);
        send_congruence({1'b1, 62'd0}, 63'd0, 1'b1);
        send_congruence(63'd3, 63'd1, 1'b0);
        send_congruence(63'd1, 63'd0, 1'b0);
        send_congruence(63'd0, 63'd0, 1'b1);
        send_congruence({1'b0, {62{1'b1}}}, {1'b0, {62{1'b1}}}, 1'b1);
        drain();
    endtask

    task automatic test_random_phase(int idle, int stall, int items);
        int first;
        send_idle_pct = idle;
        recv_stall_pct = stall;
        first = items_sent;
        while (items_sent - first < items) begin
            send_random_system();
        end
        drain();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 3000;
        for (int i = 0; i < 8; i++) send_random_system();
        drain();
    endtask

    initial begin
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_random_phase(0, 0, 450);
        test_random_phase(79, 0, 350);
        test_random_phase(0, 79, 350);
        test_random_phase(34, 34, 350);
        test_backpressure();
        if (errors == 0 && expected_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
